// File: hdl/dbpt_pkg.sv
// Package for the boundary path tracer: field widths, register indexes,
// reset values and the saturating score adder.
// No dependencies.
package dbpt_pkg;

  localparam int ROWS_W     = 7;
  localparam int COLS_W     = 9;
  localparam int MARG_W     = 5;
  localparam int FRAC_W     = 16;
  localparam int SMOOTH_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int PIX_W      = 16;
  localparam int SUM_W      = 32;
  localparam int SCORE_W    = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ROW_IDX_W  = 6;
  localparam int PATH_COL_W = 8;
  localparam int OUT_DATA_W = 16;
  localparam int TH_W       = 24;
  localparam int NUM_W      = 48;
  localparam int DVD_W      = NUM_W - 8;
  localparam int CNT_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd5;

  localparam logic [ROWS_W-1:0]   RST_ROWS   = 7'd64;
  localparam logic [COLS_W-1:0]   RST_COLS   = 9'd256;
  localparam logic [MARG_W-1:0]   RST_MARGIN = 5'd5;
  localparam logic [FRAC_W-1:0]   RST_FRAC   = 16'd19661;
  localparam logic [SMOOTH_W-1:0] RST_SMOOTH = 16'd200;
  localparam logic [GAIN_W-1:0]   RST_GAIN   = 16'd300;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam score_t SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  function automatic score_t sat_add(score_t a, score_t b);
    score_t s;
    s = a + b;
    if ((a[SCORE_W-1] == b[SCORE_W-1]) && (s[SCORE_W-1] != a[SCORE_W-1])) begin
      s = a[SCORE_W-1] ? SCORE_MIN : SCORE_MAX;
    end
    return s;
  endfunction

endpackage

// File: hdl/dp_boundary_path_tracer_top.sv
// Boundary path tracer: frame load, margin threshold, seam search and traceback.
// Uses dbpt_pkg.
//
// Pixels are taken one word per cycle in raster order; no word is taken while a
// frame is being processed or while a register write is offered. After the last
// pixel S_THR checks the margins and S_DIV runs the threshold divider. Each cell
// runs S_PIX, S_MUL, S_ACC, S_WB; on later rows S_SCAN, before S_WB, reads the
// predecessor columns (up to 2 * WINDOW_RADIUS + 1) from the score memory, one per
// cycle. Traceback runs S_TBRD, S_TBWT per row; each path word runs S_EMRD, S_EMLD,
// S_EMWT, held by output stalls. A margin error gives one word straight after the
// load. The user must write registers only between frames; this is not enforced.
module dp_boundary_path_tracer_top #(
  parameter int MAX_ROWS      = 64,
  parameter int MAX_COLS      = 256,
  parameter int WINDOW_RADIUS = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dbpt_pkg::PIX_W-1:0]       in_tdata,   // pixel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dbpt_pkg::OUT_DATA_W-1:0]  out_tdata,  // row_index, path_column, zero fill
  output logic                             out_tlast,
  output logic                             out_tuser,  // margin_error
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dbpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbpt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int XW = CW + 6;
  localparam int DW = $clog2(WINDOW_RADIUS + 1);
  localparam int PW = dbpt_pkg::SMOOTH_W + DW;

  typedef enum logic [3:0] {
    S_LOAD, S_THR, S_DIV, S_PIX, S_MUL, S_ACC, S_SCAN, S_WB,
    S_TBRD, S_TBWT, S_EMRD, S_EMLD, S_EMWT, S_ERR
  } state_t;

  state_t state_r;

  logic [dbpt_pkg::ROWS_W-1:0]   image_rows_r;
  logic [dbpt_pkg::COLS_W-1:0]   image_cols_r;
  logic [dbpt_pkg::MARG_W-1:0]   margin_r;
  logic [dbpt_pkg::FRAC_W-1:0]   frac_r;
  logic [dbpt_pkg::SMOOTH_W-1:0] smooth_r;
  logic [dbpt_pkg::GAIN_W-1:0]   gain_r;

  logic [dbpt_pkg::SUM_W-1:0] lsum_r, rsum_r;
  logic [RW-1:0] ld_row_r, row_r, tb_row_r, er_r;
  logic [CW-1:0] ld_col_r, col_r, cc_r, bcc_r;

  logic [dbpt_pkg::DVD_W-1:0] dvd_r;
  logic [dbpt_pkg::CNT_W-1:0] rem_r, count_r;
  logic [5:0]                 div_cnt_r;
  logic [dbpt_pkg::TH_W-1:0]  th_r;

  dbpt_pkg::score_t acc_r, d_r, best_r, brow_r, t_r, pen_r;
  logic [XW-1:0] lb_r, ub_r, iss_p_r, p1_r, p2_r, bp_r;
  logic          iss_on_r, v1_r, v2_r;

  logic                           out_valid_r, out_last_r, out_err_r;
  logic [dbpt_pkg::ROW_IDX_W-1:0] out_row_r;
  logic [dbpt_pkg::PATH_COL_W-1:0] out_col_r;

  logic [dbpt_pkg::PIX_W-1:0] pix_mem [MAX_ROWS*MAX_COLS];
  logic [dbpt_pkg::PIX_W-1:0] pix_q;
  dbpt_pkg::score_t           score_mem [2*MAX_COLS];
  dbpt_pkg::score_t           score_q;
  logic [CW-1:0]              bp_mem [MAX_ROWS*MAX_COLS];
  logic [CW-1:0]              bp_q;
  logic [CW-1:0]              path_mem [MAX_ROWS];
  logic [CW-1:0]              path_q;

  logic [dbpt_pkg::ROWS_W-1:0] rows_e, rows_last;
  logic [dbpt_pkg::COLS_W-1:0] cols_e, cols_last, lc9;
  logic [dbpt_pkg::MARG_W-1:0] m_lo, m_e;
  logic [dbpt_pkg::COLS_W-1:0] half;
  logic                        pix_acc, cfg_acc, cfg_known;
  logic                        ld_last, row_last, col_last;

  logic [dbpt_pkg::NUM_W-1:0]   diff48, num;
  logic [dbpt_pkg::CNT_W:0]     rem_sh;
  logic                         qbit;
  logic [dbpt_pkg::CNT_W-1:0]   rem_nxt;
  logic [dbpt_pkg::DVD_W-1:0]   dvd_nxt;

  logic signed [25:0] d_s;
  logic signed [42:0] dm;
  dbpt_pkg::score_t   d_nxt, acc_nxt, s2, pen_nxt;
  logic [XW-1:0]      xl, rad, cl, ubx, lb_nxt, ub_nxt, dx;
  logic [PW-1:0]      pen_prod;
  logic               take_best, take_row;
  logic [CW+0:0]      score_wa, score_ra;

  assign cfg_ready  = (state_r == S_LOAD);
  assign in_tready  = (state_r == S_LOAD) && !cfg_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  always_comb begin
    if (image_rows_r < 7'd2) rows_e = 7'd2;
    else if (image_rows_r > dbpt_pkg::ROWS_W'(MAX_ROWS)) rows_e = dbpt_pkg::ROWS_W'(MAX_ROWS);
    else rows_e = image_rows_r;
    if (image_cols_r < 9'd2) cols_e = 9'd2;
    else if (image_cols_r > dbpt_pkg::COLS_W'(MAX_COLS)) cols_e = dbpt_pkg::COLS_W'(MAX_COLS);
    else cols_e = image_cols_r;
    half  = cols_e >> 1;
    m_lo  = (margin_r < 5'd1) ? 5'd1 : margin_r;
    m_e   = (dbpt_pkg::COLS_W'(m_lo) > half) ? half[dbpt_pkg::MARG_W-1:0] : m_lo;
    rows_last = rows_e - 7'd1;
    cols_last = cols_e - 9'd1;
    lc9       = dbpt_pkg::COLS_W'(ld_col_r);
    ld_last   = (dbpt_pkg::ROWS_W'(ld_row_r) == rows_last) && (lc9 == cols_last);
    row_last  = (dbpt_pkg::ROWS_W'(row_r) == rows_last);
    col_last  = (dbpt_pkg::COLS_W'(col_r) == cols_last);
    pix_acc   = in_tvalid && in_tready;
    cfg_acc   = cfg_valid && cfg_ready;
    cfg_known = (cfg_index == dbpt_pkg::REG_ROWS) || (cfg_index == dbpt_pkg::REG_COLS) ||
                (cfg_index == dbpt_pkg::REG_MARGIN) || (cfg_index == dbpt_pkg::REG_FRAC) ||
                (cfg_index == dbpt_pkg::REG_SMOOTH) || (cfg_index == dbpt_pkg::REG_GAIN);
  end

  always_comb begin
    diff48  = dbpt_pkg::NUM_W'(lsum_r) - dbpt_pkg::NUM_W'(rsum_r);
    num     = {lsum_r, 16'b0} - diff48 * dbpt_pkg::NUM_W'(frac_r);
    rem_sh  = {rem_r, dvd_r[dbpt_pkg::DVD_W-1]};
    qbit    = (rem_sh >= {1'b0, count_r});
    rem_nxt = qbit ? dbpt_pkg::CNT_W'(rem_sh - {1'b0, count_r}) : rem_sh[dbpt_pkg::CNT_W-1:0];
    dvd_nxt = {dvd_r[dbpt_pkg::DVD_W-2:0], qbit};
  end

  always_comb begin
    d_s = $signed({2'b00, pix_q, 8'b0}) - $signed({2'b00, th_r});
    dm  = d_s * $signed({1'b0, gain_r});
    if (d_s[25]) d_nxt = {{(dbpt_pkg::SCORE_W-43){dm[42]}}, dm};
    else         d_nxt = {{(dbpt_pkg::SCORE_W-26){d_s[25]}}, d_s};
    acc_nxt = dbpt_pkg::sat_add(acc_r, d_r);
    xl      = XW'(col_r);
    rad     = XW'(WINDOW_RADIUS);
    cl      = XW'(cols_e) - XW'(1);
    lb_nxt  = (xl > rad) ? xl - rad : '0;
    ubx     = xl + rad;
    ub_nxt  = (ubx < cl) ? ubx : cl;
    dx      = (p1_r > xl) ? p1_r - xl : xl - p1_r;
    pen_prod = PW'(smooth_r) * PW'(dx[DW-1:0]);
    pen_nxt  = dbpt_pkg::score_t'({pen_prod, 8'b0});
    s2        = dbpt_pkg::sat_add(t_r, -pen_r);
    take_best = (p2_r == lb_r) || (s2 > best_r);
    take_row  = row_last && ((col_r == '0) || (best_r > brow_r));
    score_wa  = {row_r[0], col_r};
    score_ra  = {~row_r[0], iss_p_r[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (pix_acc) pix_mem[{ld_row_r, ld_col_r}] <= in_tdata;
    pix_q <= pix_mem[{row_r, col_r}];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WB) score_mem[score_wa] <= best_r;
    score_q <= score_mem[score_ra];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WB) bp_mem[{row_r, col_r}] <= bp_r[CW-1:0];
    bp_q <= bp_mem[{tb_row_r, cc_r}];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_TBRD) path_mem[tb_row_r] <= cc_r;
    path_q <= path_mem[er_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      image_rows_r <= dbpt_pkg::RST_ROWS;
      image_cols_r <= dbpt_pkg::RST_COLS;
      margin_r     <= dbpt_pkg::RST_MARGIN;
      frac_r       <= dbpt_pkg::RST_FRAC;
      smooth_r     <= dbpt_pkg::RST_SMOOTH;
      gain_r       <= dbpt_pkg::RST_GAIN;
      lsum_r       <= '0;
      rsum_r       <= '0;
      ld_row_r     <= '0;
      ld_col_r     <= '0;
      out_valid_r  <= 1'b0;
      iss_on_r     <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (cfg_acc && cfg_known) begin
            unique case (cfg_index)
              dbpt_pkg::REG_ROWS:   image_rows_r <= cfg_data[dbpt_pkg::ROWS_W-1:0];
              dbpt_pkg::REG_COLS:   image_cols_r <= cfg_data[dbpt_pkg::COLS_W-1:0];
              dbpt_pkg::REG_MARGIN: margin_r     <= cfg_data[dbpt_pkg::MARG_W-1:0];
              dbpt_pkg::REG_FRAC:   frac_r       <= cfg_data;
              dbpt_pkg::REG_SMOOTH: smooth_r     <= cfg_data;
              default:              gain_r       <= cfg_data;
            endcase
            lsum_r   <= '0;
            rsum_r   <= '0;
            ld_row_r <= '0;
            ld_col_r <= '0;
          end else if (pix_acc) begin
            if (lc9 < dbpt_pkg::COLS_W'(m_e)) lsum_r <= lsum_r + dbpt_pkg::SUM_W'(in_tdata);
            if (lc9 >= cols_e - dbpt_pkg::COLS_W'(m_e)) begin
              rsum_r <= rsum_r + dbpt_pkg::SUM_W'(in_tdata);
            end
            if (ld_last) begin
              state_r <= S_THR;
            end else if (lc9 == cols_last) begin
              ld_col_r <= '0;
              ld_row_r <= ld_row_r + RW'(1);
            end else begin
              ld_col_r <= ld_col_r + CW'(1);
            end
          end
        end
        S_THR: begin
          if (rsum_r >= lsum_r) begin
            out_valid_r <= 1'b1;
            out_row_r   <= '0;
            out_col_r   <= '0;
            out_last_r  <= 1'b1;
            out_err_r   <= 1'b1;
            state_r     <= S_ERR;
          end else begin
            dvd_r     <= num[dbpt_pkg::NUM_W-1:8];
            rem_r     <= '0;
            count_r   <= dbpt_pkg::CNT_W'(rows_e) * dbpt_pkg::CNT_W'(m_e);
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          dvd_r     <= dvd_nxt;
          rem_r     <= rem_nxt;
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'(dbpt_pkg::DVD_W - 1)) begin
            th_r    <= dvd_nxt[dbpt_pkg::TH_W-1:0];
            row_r   <= '0;
            col_r   <= '0;
            acc_r   <= '0;
            state_r <= S_PIX;
          end
        end
        S_PIX: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          d_r     <= d_nxt;
          lb_r    <= lb_nxt;
          ub_r    <= ub_nxt;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_nxt;
          if (row_r == '0) begin
            best_r  <= acc_nxt;
            bp_r    <= '0;
            state_r <= S_WB;
          end else begin
            iss_p_r  <= lb_r;
            iss_on_r <= 1'b1;
            v1_r     <= 1'b0;
            v2_r     <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (iss_on_r) begin
            if (iss_p_r == ub_r) iss_on_r <= 1'b0;
            else iss_p_r <= iss_p_r + XW'(1);
          end
          v1_r  <= iss_on_r;
          p1_r  <= iss_p_r;
          v2_r  <= v1_r;
          p2_r  <= p1_r;
          t_r   <= dbpt_pkg::sat_add(score_q, acc_r);
          pen_r <= pen_nxt;
          if (v2_r) begin
            if (take_best) begin
              best_r <= s2;
              bp_r   <= p2_r;
            end
            if (p2_r == ub_r) state_r <= S_WB;
          end
        end
        S_WB: begin
          if (take_row) begin
            brow_r <= best_r;
            bcc_r  <= col_r;
          end
          if (col_last) begin
            col_r <= '0;
            acc_r <= '0;
            if (row_last) begin
              tb_row_r <= row_r;
              cc_r     <= take_row ? col_r : bcc_r;
              state_r  <= S_TBRD;
            end else begin
              row_r   <= row_r + RW'(1);
              state_r <= S_PIX;
            end
          end else begin
            col_r   <= col_r + CW'(1);
            state_r <= S_PIX;
          end
        end
        S_TBRD: begin
          state_r <= S_TBWT;
        end
        S_TBWT: begin
          cc_r <= bp_q;
          if (tb_row_r == '0) begin
            er_r    <= '0;
            state_r <= S_EMRD;
          end else begin
            tb_row_r <= tb_row_r - RW'(1);
            state_r  <= S_TBRD;
          end
        end
        S_EMRD: begin
          state_r <= S_EMLD;
        end
        S_EMLD: begin
          out_valid_r <= 1'b1;
          out_row_r   <= dbpt_pkg::ROW_IDX_W'(er_r);
          out_col_r   <= dbpt_pkg::PATH_COL_W'(path_q);
          out_last_r  <= (dbpt_pkg::ROWS_W'(er_r) == rows_last);
          out_err_r   <= 1'b0;
          state_r     <= S_EMWT;
        end
        S_EMWT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (dbpt_pkg::ROWS_W'(er_r) == rows_last) begin
              lsum_r   <= '0;
              rsum_r   <= '0;
              ld_row_r <= '0;
              ld_col_r <= '0;
              state_r  <= S_LOAD;
            end else begin
              er_r    <= er_r + RW'(1);
              state_r <= S_EMRD;
            end
          end
        end
        default: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            lsum_r      <= '0;
            rsum_r      <= '0;
            ld_row_r    <= '0;
            ld_col_r    <= '0;
            state_r     <= S_LOAD;
          end
        end
      endcase
    end
  end

endmodule

// File: hdl/dbpt_checker.sv
// Port-level checks for the boundary path tracer, bound to the top level.
// Depends on dbpt_pkg and dp_boundary_path_tracer_top.
module dbpt_port_props (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [dbpt_pkg::PIX_W-1:0]      in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dbpt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [dbpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [dbpt_pkg::CFG_DATA_W-1:0] cfg_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("pixel accepted while a result is pending");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("margin error word is malformed");

  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && $past(in_tvalid && in_tready) |-> out_tuser)
    else $error("path word straight after the load");

endmodule

bind dp_boundary_path_tracer_top dbpt_port_props u_dbpt_port_props (.*);

// File: tb/dbpt_checker.sv
`timescale 1ns / 1ps
// Checker for the boundary path tracer: watches the configuration, pixel and
// path channels, predicts every path word and compares it. Uses dbpt_pkg.
module dbpt_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [dbpt_pkg::PIX_W-1:0]      in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [dbpt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  input  logic                            out_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dbpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbpt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              words_seen,
  output int                              frames_done,
  output int                              error_frames
);

  typedef struct {
    logic [dbpt_pkg::ROW_IDX_W-1:0]  row;
    logic [dbpt_pkg::PATH_COL_W-1:0] col;
    logic                            last;
    logic                            merr;
  } path_word_t;

  path_word_t path_queue[$];

  logic [dbpt_pkg::ROWS_W-1:0]   rows_reg;
  logic [dbpt_pkg::COLS_W-1:0]   cols_reg;
  logic [dbpt_pkg::MARG_W-1:0]   marg_reg;
  logic [dbpt_pkg::FRAC_W-1:0]   frac_reg;
  logic [dbpt_pkg::SMOOTH_W-1:0] smooth_reg;
  logic [dbpt_pkg::GAIN_W-1:0]   gain_reg;

  logic [dbpt_pkg::PIX_W-1:0] frame_pix [0:16383];
  logic [7:0]       trail [0:16383];
  longint           cell_score [0:1][0:255];
  logic [31:0]      lsum, rsum;
  int unsigned      load_pos;

  function automatic longint add_clamped(longint a, longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) s = 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a < 0 && b < 0 && s >= 0) s = 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  task automatic predict_path(int unsigned nr, int unsigned nc, int unsigned m);
    longint unsigned num, th, cnt;
    longint acc, d, best, s, pen, best_last;
    int unsigned lo, hi, bp, pick;
    logic [7:0] cols_of_row [0:63];
    path_word_t w;
    if (rsum >= lsum) begin
      w.row = '0; w.col = '0; w.last = 1'b1; w.merr = 1'b1;
      path_queue = {path_queue, w};
      error_frames++;
      return;
    end
    cnt = longint'(nr) * m;
    num = longint'(lsum) * 65536 - longint'(lsum - rsum) * frac_reg;
    th = (num * 256) / (cnt * 65536);
    pick = 0;
    best_last = 0;
    for (int unsigned r = 0; r < nr; r++) begin
      acc = 0;
      for (int unsigned x = 0; x < nc; x++) begin
        d = longint'(frame_pix[r*nc+x]) * 256 - longint'(th);
        if (d < 0) d = d * longint'(gain_reg);
        acc = add_clamped(acc, d);
        best = acc;
        bp = 0;
        if (r != 0) begin
          lo = (x > 7) ? x - 7 : 0;
          hi = (x + 7 < nc - 1) ? x + 7 : nc - 1;
          for (int unsigned p = lo; p <= hi; p++) begin
            pen = longint'(smooth_reg) * longint'((p > x) ? p - x : x - p) * 256;
            s = add_clamped(add_clamped(cell_score[(r+1)%2][p], acc), -pen);
            if (p == lo || s > best) begin
              best = s;
              bp = p;
            end
          end
        end
        cell_score[r%2][x] = best;
        trail[r*nc+x] = bp[7:0];
        if (r == nr - 1 && (x == 0 || best > best_last)) begin
          best_last = best;
          pick = x;
        end
      end
    end
    for (int r = nr - 1; r >= 0; r--) begin
      cols_of_row[r] = pick[7:0];
      pick = trail[r*nc+pick];
    end
    for (int unsigned r = 0; r < nr; r++) begin
      w.row = r[5:0]; w.col = cols_of_row[r]; w.last = (r == nr - 1); w.merr = 1'b0;
      path_queue = {path_queue, w};
    end
  endtask

  task automatic take_pixel(logic [dbpt_pkg::PIX_W-1:0] v);
    int unsigned nr, nc, m, c;
    nr = (rows_reg < 2) ? 2 : (rows_reg > 64) ? 64 : rows_reg;
    nc = (cols_reg < 2) ? 2 : (cols_reg > 256) ? 256 : cols_reg;
    m = (marg_reg < 1) ? 1 : marg_reg;
    if (m > nc / 2) m = nc / 2;
    if (load_pos >= nr * nc) load_pos = 0;
    frame_pix[load_pos] = v;
    c = load_pos % nc;
    if (c < m) lsum += v;
    if (c >= nc - m) rsum += v;
    if (load_pos + 1 < nr * nc) begin
      load_pos++;
    end else begin
      predict_path(nr, nc, m);
      frames_done++;
      load_pos = 0; lsum = 0; rsum = 0;
    end
  endtask

  always @(posedge clk) begin
    path_word_t e;
    if (!rst_n) begin
      rows_reg = dbpt_pkg::RST_ROWS; cols_reg = dbpt_pkg::RST_COLS;
      marg_reg = dbpt_pkg::RST_MARGIN; frac_reg = dbpt_pkg::RST_FRAC;
      smooth_reg = dbpt_pkg::RST_SMOOTH; gain_reg = dbpt_pkg::RST_GAIN;
      lsum = 0; rsum = 0; load_pos = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= dbpt_pkg::REG_GAIN) begin
        case (cfg_index)
          dbpt_pkg::REG_ROWS:   rows_reg = cfg_data[dbpt_pkg::ROWS_W-1:0];
          dbpt_pkg::REG_COLS:   cols_reg = cfg_data[dbpt_pkg::COLS_W-1:0];
          dbpt_pkg::REG_MARGIN: marg_reg = cfg_data[dbpt_pkg::MARG_W-1:0];
          dbpt_pkg::REG_FRAC:   frac_reg = cfg_data;
          dbpt_pkg::REG_SMOOTH: smooth_reg = cfg_data;
          dbpt_pkg::REG_GAIN:   gain_reg = cfg_data;
          default: ;
        endcase
        load_pos = 0; lsum = 0; rsum = 0;
      end
      if (in_tvalid && in_tready) take_pixel(in_tdata);
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (path_queue.size() == 0) begin
          $error("unexpected path word %h", out_tdata);
          fail_count++;
        end else begin
          e = path_queue.pop_front();
          if (out_tdata[5:0] !== e.row) begin
            $error("row_index expected %0d actual %0d", e.row, out_tdata[5:0]);
            fail_count++;
          end
          if (out_tdata[13:6] !== e.col) begin
            $error("path_column expected %0d actual %0d", e.col, out_tdata[13:6]);
            fail_count++;
          end
          if (out_tlast !== e.last) begin
            $error("last_row expected %0d actual %0d", e.last, out_tlast);
            fail_count++;
          end
          if (out_tuser !== e.merr) begin
            $error("margin_error expected %0d actual %0d", e.merr, out_tuser);
            fail_count++;
          end
        end
      end
    end
    pending = path_queue.size();
  end

  initial begin
    fail_count = 0; pending = 0; words_seen = 0; frames_done = 0; error_frames = 0;
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the boundary path tracer testbench: clock, reset, frame and register
// stimulus and the verdict. Uses dbpt_pkg, dbpt_checker and the block itself.
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [dbpt_pkg::PIX_W-1:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0, out_tlast, out_tuser;
  logic [dbpt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [dbpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dbpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending, words_seen, frames_done, error_frames;
  int burst_left = 1, gap_left = 0, pixels_sent = 0, cfg_writes = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  int unsigned rows_w = 64, cols_w = 256, marg_w = 5;

  always #1 clk = ~clk;

  dp_boundary_path_tracer_top uut (.*);

  dbpt_checker u_check (.*);

  always @(posedge clk) begin
    if (!hold_done && words_seen >= 10) begin
      hold_done = 1'b1;
      hold_cycles = 400;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if ((words_seen / 16) % 3 == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(logic [dbpt_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      dbpt_pkg::REG_ROWS:   rows_w = v & 32'h7F;
      dbpt_pkg::REG_COLS:   cols_w = v & 32'h1FF;
      dbpt_pkg::REG_MARGIN: marg_w = v & 32'h1F;
      default: ;
    endcase
  endtask

  task automatic send_pixel(logic [dbpt_pkg::PIX_W-1:0] v);
    while (gap_left > 0) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Kinds: 0 bright left and dark right with a random step, 1 uniform noise,
  // 2 dark left and bright right, 3 full-scale extremes.
  task automatic send_frame(int kind, int unsigned count = 0);
    int unsigned nr, nc, m, c, step, n;
    logic [dbpt_pkg::PIX_W-1:0] v;
    nr = (rows_w < 2) ? 2 : (rows_w > 64) ? 64 : rows_w;
    nc = (cols_w < 2) ? 2 : (cols_w > 256) ? 256 : cols_w;
    m = (marg_w < 1) ? 1 : marg_w;
    if (m > nc / 2) m = nc / 2;
    n = (count == 0) ? nr * nc : count;
    step = $urandom_range(0, nc - 1);
    for (int unsigned i = 0; i < n; i++) begin
      c = i % nc;
      case (kind)
        0: begin
          if (c < m) v = $urandom_range(40000, 65535);
          else if (c >= nc - m) v = $urandom_range(0, 20000);
          else if (c + $urandom_range(0, 2) < step + 1) v = $urandom_range(30000, 65535);
          else v = $urandom_range(0, 35000);
        end
        1: v = $urandom;
        2: v = (c < nc / 2) ? $urandom_range(0, 20000) : $urandom_range(20000, 65535);
        default: v = (c < nc / 2) ? 16'hFFFF : 16'h0000;
      endcase
      send_pixel(v);
    end
  endtask

  initial begin
    int unsigned kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(dbpt_pkg::REG_ROWS, 2); write_reg(dbpt_pkg::REG_COLS, 4);
    write_reg(dbpt_pkg::REG_MARGIN, 1); write_reg(dbpt_pkg::REG_FRAC, 0);
    write_reg(dbpt_pkg::REG_SMOOTH, 0); write_reg(dbpt_pkg::REG_GAIN, 0);
    send_frame(3);
    drain;
    write_reg(dbpt_pkg::REG_ROWS, 3); write_reg(dbpt_pkg::REG_COLS, 6);
    write_reg(dbpt_pkg::REG_FRAC, 65535);
    write_reg(dbpt_pkg::REG_SMOOTH, 65535); write_reg(dbpt_pkg::REG_GAIN, 65535);
    send_frame(0);
    send_frame(2);
    send_frame(3);
    drain;
    write_reg(dbpt_pkg::REG_ROWS, 0); write_reg(dbpt_pkg::REG_COLS, 1);
    write_reg(dbpt_pkg::REG_MARGIN, 0);
    send_frame(0);
    send_frame(2);
    drain;
    write_reg(dbpt_pkg::REG_ROWS, 127); write_reg(dbpt_pkg::REG_COLS, 2);
    write_reg(dbpt_pkg::REG_MARGIN, 31);
    write_reg(dbpt_pkg::REG_SMOOTH, 200); write_reg(dbpt_pkg::REG_GAIN, 300);
    write_reg(dbpt_pkg::REG_FRAC, 19661);
    send_frame(0);
    drain;
    write_reg(dbpt_pkg::REG_ROWS, 2); write_reg(dbpt_pkg::REG_COLS, 511);
    write_reg(dbpt_pkg::REG_MARGIN, 16);
    send_frame(0, 24);
    drain;
    write_reg(dbpt_pkg::REG_ROWS, 3); write_reg(dbpt_pkg::REG_COLS, 5);
    write_reg(dbpt_pkg::REG_MARGIN, 2);
    send_frame(1, 7);
    drain;
    write_reg(3'd6, 12345);
    send_frame(1, 4);
    drain;
    write_reg(3'd7, 0);
    write_reg(dbpt_pkg::REG_SMOOTH, 7);
    send_frame(0);
    drain;

    while (pixels_sent < 420) begin
      for (int i = 0; i < 6; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          case (i)
            0: write_reg(dbpt_pkg::REG_ROWS, ($urandom_range(0, 9) == 0) ?
                         $urandom_range(0, 127) : $urandom_range(2, 8));
            1: write_reg(dbpt_pkg::REG_COLS, ($urandom_range(0, 9) == 0) ?
                         $urandom_range(0, 40) : $urandom_range(2, 24));
            2: write_reg(dbpt_pkg::REG_MARGIN, $urandom_range(0, 31));
            3: write_reg(dbpt_pkg::REG_FRAC, $urandom);
            4: write_reg(dbpt_pkg::REG_SMOOTH, ($urandom_range(0, 1) == 0) ?
                         $urandom_range(0, 300) : $urandom);
            default: write_reg(dbpt_pkg::REG_GAIN, ($urandom_range(0, 1) == 0) ?
                               $urandom_range(0, 400) : $urandom);
          endcase
        end
      end
      if (rows_w > 8 || rows_w < 2) write_reg(dbpt_pkg::REG_ROWS, $urandom_range(2, 8));
      repeat ($urandom_range(1, 2)) begin
        kind = $urandom_range(0, 9);
        send_frame((kind < 7) ? 0 : (kind < 9) ? 1 : 2);
      end
      drain;
    end

    $display("Covered %0d pixels, %0d frames (%0d with a margin error), %0d register writes,",
             pixels_sent, frames_done, error_frames, cfg_writes);
    $display("and %0d path words under bursty input and stalled output.", words_seen);
    if (fail_count == 0) begin
      $display("dp_boundary_path_tracer_top verification clean");
    end else begin
      $display("dp_boundary_path_tracer_top verification failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("dp_boundary_path_tracer_top verification failed");
    $finish;
  end

endmodule
